FILE: sv/vsa_pkg.sv
// Shared types, field widths and action codes for the voice slot allocator.
`timescale 1ns / 1ps

package vsa_pkg;

  localparam int ACTION_W     = 4;
  localparam int SLOT_FIELD_W = 4;
  localparam int AUDIO_W      = 8;
  localparam int COUNT_W      = 9;
  localparam int STAMP_W      = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ACTION_W-1:0] ACT_PLAY       = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_PLAY_LOOP  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_PAUSE      = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_RESUME     = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_STOP       = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_UNBIND     = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_STREAM_END = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_PAUSE_ALL  = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_RESUME_ALL = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_STOP_ALL   = 4'd9;

  // How the back end has to carry out a command
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_PLAY,
    KIND_SINGLE,
    KIND_GROUP
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [ACTION_W-1:0]     action;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [AUDIO_W-1:0]      audio_index;
  } cmd_t;

endpackage

FILE: sv/vsa_if.sv
// Channel interfaces: voice command requests, results and the clip count write.
`timescale 1ns / 1ps

interface vsa_req_if;
  logic                              valid;
  logic                              ready;
  logic [vsa_pkg::ACTION_W-1:0]      action;
  logic [vsa_pkg::SLOT_FIELD_W-1:0]  slot;
  logic [vsa_pkg::AUDIO_W-1:0]       audio_index;

  modport source (output valid, action, slot, audio_index, input ready);
  modport sink   (input valid, action, slot, audio_index, output ready);
endinterface

interface vsa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [vsa_pkg::SLOT_FIELD_W-1:0]  result_slot;
  logic                              accepted;
  logic                              stole_voice;
  logic                              restarted;

  modport source (output valid, result_slot, accepted, stole_voice, restarted, input ready);
  modport sink   (input valid, result_slot, accepted, stole_voice, restarted, output ready);
endinterface

interface vsa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vsa_pkg::COUNT_W-1:0]       audio_count;

  modport source (output valid, audio_count, input ready);
  modport sink   (input valid, audio_count, output ready);
endinterface

FILE: sv/vsa_queue.sv
// Short command queue between the classifying front end and the slot engine.
`timescale 1ns / 1ps

module vsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vsa_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output vsa_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int PTR_W = $clog2(vsa_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_C = (PTR_W+1)'(vsa_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(vsa_pkg::QUEUE_DEPTH - 1);

  vsa_pkg::cmd_t  entry [vsa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == DEPTH_C);
  assign pop_valid = (count != '0);
  assign pop_cmd   = entry[rd_ptr];

  // Store a beat at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/vsa_front.sv
// Front end: takes request beats, holds the clip count and classifies commands.
`timescale 1ns / 1ps

module vsa_front #(
  parameter int SLOT_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  vsa_req_if.sink       req,
  vsa_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          push,
  output vsa_pkg::cmd_t push_cmd
);

  logic [vsa_pkg::COUNT_W-1:0] audio_count;
  logic                        slot_ok;
  logic                        clip_ok;

  // Hold the number of bound clips
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_count <= '0;
    end else if (cfg.valid) begin
      audio_count <= cfg.audio_count;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  assign slot_ok = ({{(32 - vsa_pkg::SLOT_FIELD_W){1'b0}}, req.slot} < 32'(SLOT_COUNT));
  assign clip_ok = ({{(vsa_pkg::COUNT_W - vsa_pkg::AUDIO_W){1'b0}}, req.audio_index}
                    < audio_count);

  // Classify the command for the slot engine
  always_comb begin
    push_cmd.action      = req.action;
    push_cmd.slot        = req.slot;
    push_cmd.audio_index = req.audio_index;
    case (req.action)
      vsa_pkg::ACT_PLAY, vsa_pkg::ACT_PLAY_LOOP: begin
        push_cmd.kind = clip_ok ? vsa_pkg::KIND_PLAY : vsa_pkg::KIND_NOP;
      end
      vsa_pkg::ACT_PAUSE, vsa_pkg::ACT_RESUME, vsa_pkg::ACT_STOP,
      vsa_pkg::ACT_STREAM_END: begin
        push_cmd.kind = slot_ok ? vsa_pkg::KIND_SINGLE : vsa_pkg::KIND_NOP;
      end
      vsa_pkg::ACT_UNBIND, vsa_pkg::ACT_PAUSE_ALL, vsa_pkg::ACT_RESUME_ALL,
      vsa_pkg::ACT_STOP_ALL: begin
        push_cmd.kind = vsa_pkg::KIND_GROUP;
      end
      default: begin
        push_cmd.kind = vsa_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

FILE: sv/vsa_back.sv
// Slot engine: scans the voice slot table, applies commands and registers results.
`timescale 1ns / 1ps

module vsa_back #(
  parameter int SLOT_COUNT = 16,
  parameter int CLIP_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vsa_pkg::cmd_t q_cmd,
  output logic          q_pop,
  vsa_rsp_if.source     rsp
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W:0] SCAN_END = (SLOT_W+1)'(SLOT_COUNT);

  typedef struct packed {
    logic [vsa_pkg::STAMP_W-1:0] stamp;
    logic                        looping;
    logic                        paused;
    logic [CLIP_BITS-1:0]        clip;
  } row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SGL,
    S_SCAN,
    S_GRANT,
    S_DONE
  } state_t;

  // Slot table and its entry valid bits
  row_t                    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   row_valid;
  row_t                    rd_row;
  logic                    rd_vld;

  logic                    rd_en;
  logic [SLOT_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  row_t                    wr_row;

  state_t                  state;
  vsa_pkg::cmd_t           cmd;
  logic [SLOT_W:0]         scan_idx;
  logic                    rd_pend;
  logic [SLOT_W-1:0]       rd_idx;
  logic                    found_free;
  logic [SLOT_W-1:0]       free_idx;
  logic                    found_nl;
  logic [vsa_pkg::STAMP_W-1:0] best_stamp;
  logic [SLOT_W-1:0]       best_idx;
  logic                    acc;
  logic                    stole;
  logic                    restart;
  logic [vsa_pkg::STAMP_W-1:0] stamp_counter;

  logic                    out_valid;
  logic [vsa_pkg::SLOT_FIELD_W-1:0] out_slot;
  logic                    out_acc;
  logic                    out_stole;
  logic                    out_restart;

  row_t                    row_q;
  row_t                    row_mod;
  logic                    changed;
  logic                    restart_c;
  logic [SLOT_W-1:0]       pick;
  logic [SLOT_W+vsa_pkg::SLOT_FIELD_W-1:0] pick_wide;
  logic [SLOT_W+vsa_pkg::SLOT_FIELD_W-1:0] slot_wide;
  logic [CLIP_BITS+vsa_pkg::AUDIO_W-1:0]   clip_wide;
  logic [CLIP_BITS-1:0]    clip_in;
  logic                    is_play;

  assign row_q     = rd_vld ? rd_row : '0;
  assign pick      = found_free ? free_idx : best_idx;
  assign pick_wide = {{vsa_pkg::SLOT_FIELD_W{1'b0}}, pick};
  assign slot_wide = {{SLOT_W{1'b0}}, q_cmd.slot};
  assign clip_wide = {{CLIP_BITS{1'b0}}, cmd.audio_index};
  assign clip_in   = clip_wide[CLIP_BITS-1:0];
  assign is_play   = (cmd.action == vsa_pkg::ACT_PLAY) ||
                     (cmd.action == vsa_pkg::ACT_PLAY_LOOP);

  // Apply a slot command to the row just read
  always_comb begin
    row_mod   = row_q;
    changed   = 1'b0;
    restart_c = 1'b0;
    case (cmd.action)
      vsa_pkg::ACT_PAUSE, vsa_pkg::ACT_PAUSE_ALL: begin
        if (row_q.stamp != '0 && !row_q.paused) begin
          row_mod.paused = 1'b1;
          changed        = 1'b1;
        end
      end
      vsa_pkg::ACT_RESUME, vsa_pkg::ACT_RESUME_ALL: begin
        if (row_q.stamp != '0 && row_q.paused) begin
          row_mod.paused = 1'b0;
          changed        = 1'b1;
        end
      end
      vsa_pkg::ACT_STOP, vsa_pkg::ACT_STOP_ALL: begin
        if (row_q.stamp != '0) begin
          row_mod.stamp = '0;
          changed       = 1'b1;
        end
      end
      vsa_pkg::ACT_UNBIND: begin
        if (row_q.stamp != '0 && row_q.clip == clip_in) begin
          row_mod.stamp = '0;
          changed       = 1'b1;
        end
      end
      vsa_pkg::ACT_STREAM_END: begin
        if (row_q.stamp != '0 && !row_q.paused) begin
          changed = 1'b1;
          if (row_q.looping) begin
            restart_c = 1'b1;
          end else begin
            row_mod.stamp = '0;
          end
        end
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  // Drive table port and queue pop
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[SLOT_W-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_row  = row_mod;
    q_pop   = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.kind == vsa_pkg::KIND_SINGLE) begin
          rd_en   = 1'b1;
          rd_addr = slot_wide[SLOT_W-1:0];
        end
      end
      S_SGL: begin
        wr_en = changed;
      end
      S_SCAN: begin
        rd_en = (scan_idx != SCAN_END);
        wr_en = rd_pend && (cmd.kind == vsa_pkg::KIND_GROUP) && changed;
      end
      S_GRANT: begin
        wr_en          = 1'b1;
        wr_addr        = pick;
        wr_row.stamp   = stamp_counter + 1'b1;
        wr_row.looping = (cmd.action == vsa_pkg::ACT_PLAY_LOOP);
        wr_row.paused  = 1'b0;
        wr_row.clip    = clip_in;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Slot table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  // Entry valid bits: an unwritten slot reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  // Sequence each command and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      stamp_counter <= '0;
      rd_pend       <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one replaces it below
      if (rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            acc        <= 1'b0;
            stole      <= 1'b0;
            restart    <= 1'b0;
            scan_idx   <= '0;
            rd_pend    <= 1'b0;
            found_free <= 1'b0;
            found_nl   <= 1'b0;
            best_stamp <= '0;
            rd_idx     <= slot_wide[SLOT_W-1:0];
            case (q_cmd.kind)
              vsa_pkg::KIND_SINGLE:                    state <= S_SGL;
              vsa_pkg::KIND_PLAY, vsa_pkg::KIND_GROUP: state <= S_SCAN;
              default:                                 state <= S_DONE;
            endcase
          end
        end
        S_SGL: begin
          acc     <= changed;
          restart <= restart_c;
          state   <= S_DONE;
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_idx   <= scan_idx[SLOT_W-1:0];
            scan_idx <= scan_idx + 1'b1;
          end
          rd_pend <= rd_en;
          if (rd_pend) begin
            if (changed && cmd.kind == vsa_pkg::KIND_GROUP) begin
              acc <= 1'b1;
            end
            if (row_q.stamp == '0 && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (!row_q.looping && (!found_nl || row_q.stamp < best_stamp)) begin
              found_nl   <= 1'b1;
              best_stamp <= row_q.stamp;
              best_idx   <= rd_idx;
            end
          end
          if (!rd_en && !rd_pend) begin
            if (cmd.kind == vsa_pkg::KIND_PLAY && (found_free || found_nl)) begin
              state <= S_GRANT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_GRANT: begin
          stamp_counter <= stamp_counter + 1'b1;
          acc           <= 1'b1;
          stole         <= !found_free;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_slot    <= is_play ? (acc ? pick_wide[vsa_pkg::SLOT_FIELD_W-1:0] : '0)
                                   : cmd.slot;
            out_acc     <= acc;
            out_stole   <= stole;
            out_restart <= restart;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_slot = out_slot;
  assign rsp.accepted    = out_acc;
  assign rsp.stole_voice = out_stole;
  assign rsp.restarted   = out_restart;

endmodule

FILE: sv/voice_slot_allocator.sv
// Voice slot allocator top level: front end, command queue and slot engine.
//
// Channels: req carries one voice command a beat (action, slot, audio_index);
// rsp returns exactly one result beat per command, in command order (granted
// or echoed slot, accepted, stole_voice, restarted); cfg writes the number of
// bound clips and is always ready.
// Commands that change nothing (refused play, bad slot, unused action) go
// straight to the result register; pause, resume, stop and stream end of one
// slot read that slot and write it back if it changes; group commands, and a
// play refused as every slot loops, walk the whole table; a granted play walks
// it and then writes its chosen slot.
// Play and group commands walk the slot table one entry a cycle through its
// single read port; that walk sets the cost of those commands.
// A two-entry queue sits between front end and engine, so requests are still
// taken while the engine works or a result waits; req.ready drops only when
// that queue is full. A stalled rsp holds its beat; the engine finishes the
// next command and then waits for the result register to free up.
// Reset (rst, synchronous) frees every slot, clears the age counter and the
// clip count; no clearing pass is needed.
`timescale 1ns / 1ps

module voice_slot_allocator #(
  parameter int SLOT_COUNT = 16,
  parameter int CLIP_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst,
  vsa_req_if.sink   req,
  vsa_rsp_if.source rsp,
  vsa_cfg_if.sink   cfg
);

  logic          q_push;
  vsa_pkg::cmd_t q_push_cmd;
  logic          q_full;
  logic          q_valid;
  vsa_pkg::cmd_t q_cmd;
  logic          q_pop;

  vsa_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  vsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd),
    .pop       (q_pop)
  );

  vsa_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .CLIP_BITS  (CLIP_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  // The engine never pops an empty queue
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // The front end never pushes into a full queue
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // A steal or a restart is always reported as accepted
  a_flags_accepted: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.stole_voice || rsp.restarted)) |-> rsp.accepted)
    else $error("steal or restart flagged without accept");

  // A result never claims both a steal and a restart
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.stole_voice && rsp.restarted))
    else $error("steal and restart flagged together");
`endif

endmodule
